@@ sv/lfpm_pkg.sv @@
// Shared types and constants for the line follower PID motor mixer.
// No dependencies; imported by every module of the block.
package lfpm_pkg;

	localparam int SAMPLE_W = 12;
	localparam int GAIN_W   = 12;
	localparam int LIMIT_W  = 8;
	localparam int SPEED_W  = 8;
	localparam int ERR_W    = 3;
	localparam int SUM_W    = 9;
	localparam int DRIVE_W  = 13;
	localparam int CFG_W    = 12;
	localparam int IDX_W    = 3;
	localparam int ACC_W    = 24;

	localparam logic [SAMPLE_W-1:0] THRESHOLD_RST = 12'd3000;
	localparam logic [GAIN_W-1:0]   GAIN_P_RST    = 12'd256;
	localparam logic [GAIN_W-1:0]   GAIN_I_RST    = 12'd128;
	localparam logic [GAIN_W-1:0]   GAIN_D_RST    = 12'd26;
	localparam logic [LIMIT_W-1:0]  LIMIT_RST     = 8'd120;
	localparam logic [SPEED_W-1:0]  BASE_RST      = 8'd100;
	localparam logic [SPEED_W-1:0]  MAX_RST       = 8'd255;

	localparam logic signed [15:0] DRIVE_MAX = 16'sd4095;
	localparam logic signed [15:0] DRIVE_MIN = -16'sd4096;

	typedef enum logic [IDX_W-1:0] {
		CFG_THRESHOLD = 3'd0,
		CFG_GAIN_P    = 3'd1,
		CFG_GAIN_I    = 3'd2,
		CFG_GAIN_D    = 3'd3,
		CFG_LIMIT     = 3'd4,
		CFG_BASE      = 3'd5,
		CFG_MAX       = 3'd6
	} cfg_idx_t;

	localparam logic [1:0] BRIDGE_EQUAL = 2'd0;
	localparam logic [1:0] BRIDGE_LEFT  = 2'd1;
	localparam logic [1:0] BRIDGE_RIGHT = 2'd2;

	typedef struct packed {
		logic [1:0]         bridge_code;
		logic [SPEED_W-1:0] right_duty;
		logic [SPEED_W-1:0] left_duty;
	} mix_t;

	typedef struct packed {
		mix_t                      mix;
		logic signed [DRIVE_W-1:0] drive;
		logic signed [ERR_W-1:0]   line_error;
	} result_t;

endpackage

@@ sv/lfpm_classify.sv @@
// Sensor pattern to line error classification.
// Depends on lfpm_pkg.
module lfpm_classify #(
	parameter int SAMPLE_BITS = 12
) (
	input  logic [lfpm_pkg::SAMPLE_W-1:0] left_sample,
	input  logic [lfpm_pkg::SAMPLE_W-1:0] middle_sample,
	input  logic [lfpm_pkg::SAMPLE_W-1:0] right_sample,
	input  logic [lfpm_pkg::SAMPLE_W-1:0] threshold,
	output logic signed [lfpm_pkg::ERR_W-1:0] line_error
);
	import lfpm_pkg::*;

	localparam logic [SAMPLE_W-1:0] SMASK = SAMPLE_W'((64'd1 << SAMPLE_BITS) - 64'd1);

	logic sl, sm, sr;

	assign sl = (left_sample & SMASK) < threshold;
	assign sm = (middle_sample & SMASK) < threshold;
	assign sr = (right_sample & SMASK) < threshold;

	always_comb begin
		unique case ({sl, sm, sr})
			3'b100:  line_error = -3'sd2;
			3'b110:  line_error = -3'sd1;
			3'b011:  line_error = 3'sd1;
			3'b001:  line_error = 3'sd2;
			default: line_error = 3'sd0;
		endcase
	end

endmodule

@@ sv/lfpm_pid.sv @@
// PID law: clamped integral update, Q16.8 accumulate, truncate, saturate.
// Depends on lfpm_pkg.
module lfpm_pid (
	input  logic signed [lfpm_pkg::ERR_W-1:0]   line_error,
	input  logic signed [lfpm_pkg::ERR_W-1:0]   prev_error,
	input  logic signed [lfpm_pkg::SUM_W-1:0]   err_sum,
	input  logic [lfpm_pkg::GAIN_W-1:0]         gain_p,
	input  logic [lfpm_pkg::GAIN_W-1:0]         gain_i,
	input  logic [lfpm_pkg::GAIN_W-1:0]         gain_d,
	input  logic [lfpm_pkg::LIMIT_W-1:0]        limit,
	output logic signed [lfpm_pkg::SUM_W-1:0]   err_sum_nxt,
	output logic signed [lfpm_pkg::DRIVE_W-1:0] drive
);
	import lfpm_pkg::*;

	logic signed [SUM_W:0]   sum_raw, lim_pos, lim_neg;
	logic signed [ERR_W:0]   diff;
	logic signed [ACC_W-1:0] gp, gi, gd, ev, sv, dv;
	logic signed [ACC_W-1:0] acc, acc_adj, shifted;
	logic signed [15:0]      drv_full;

	assign lim_pos = signed'({2'b00, limit});
	assign lim_neg = -lim_pos;

	always_comb begin
		if (line_error == 3'sd0) begin
			sum_raw = '0;
		end else begin
			sum_raw = (SUM_W+1)'(err_sum) + (SUM_W+1)'(line_error);
		end
		if (sum_raw > lim_pos) begin
			err_sum_nxt = SUM_W'(lim_pos);
		end else if (sum_raw < lim_neg) begin
			err_sum_nxt = SUM_W'(lim_neg);
		end else begin
			err_sum_nxt = SUM_W'(sum_raw);
		end
	end

	assign diff = (ERR_W+1)'(line_error) - (ERR_W+1)'(prev_error);

	assign gp = ACC_W'(signed'({1'b0, gain_p}));
	assign gi = ACC_W'(signed'({1'b0, gain_i}));
	assign gd = ACC_W'(signed'({1'b0, gain_d}));
	assign ev = ACC_W'(line_error);
	assign sv = ACC_W'(err_sum_nxt);
	assign dv = ACC_W'(diff);

	assign acc     = gp * ev + gi * sv + gd * dv;
	// round toward zero on negative sums
	assign acc_adj = acc[ACC_W-1] ? acc + ACC_W'(255) : acc;
	assign shifted = acc_adj >>> 8;
	assign drv_full = 16'(shifted);

	always_comb begin
		if (drv_full > DRIVE_MAX) begin
			drive = DRIVE_W'(DRIVE_MAX);
		end else if (drv_full < DRIVE_MIN) begin
			drive = DRIVE_W'(DRIVE_MIN);
		end else begin
			drive = DRIVE_W'(drv_full);
		end
	end

endmodule

@@ sv/lfpm_mixer.sv @@
// Differential motor mixer: clamped duties and H-bridge direction code.
// Depends on lfpm_pkg.
module lfpm_mixer (
	input  logic signed [lfpm_pkg::DRIVE_W-1:0] drive,
	input  logic [lfpm_pkg::SPEED_W-1:0]        base_speed,
	input  logic [lfpm_pkg::SPEED_W-1:0]        max_speed,
	output lfpm_pkg::mix_t                      mix
);
	import lfpm_pkg::*;

	localparam int MW = DRIVE_W + 1;

	logic signed [MW-1:0] base_s, max_s, drv_s, l_sum, r_sum;
	logic [SPEED_W-1:0]   l_duty, r_duty;

	assign base_s = signed'({(MW-SPEED_W)'(0), base_speed});
	assign max_s  = signed'({(MW-SPEED_W)'(0), max_speed});
	assign drv_s  = MW'(drive);
	assign l_sum  = base_s + drv_s;
	assign r_sum  = base_s - drv_s;

	always_comb begin
		if (l_sum < 0) begin
			l_duty = '0;
		end else if (l_sum > max_s) begin
			l_duty = max_speed;
		end else begin
			l_duty = l_sum[SPEED_W-1:0];
		end
		if (r_sum < 0) begin
			r_duty = '0;
		end else if (r_sum > max_s) begin
			r_duty = max_speed;
		end else begin
			r_duty = r_sum[SPEED_W-1:0];
		end
		mix.left_duty  = l_duty;
		mix.right_duty = r_duty;
		priority if (l_duty > r_duty) begin
			mix.bridge_code = BRIDGE_LEFT;
		end else if (r_duty > l_duty) begin
			mix.bridge_code = BRIDGE_RIGHT;
		end else begin
			mix.bridge_code = BRIDGE_EQUAL;
		end
	end

endmodule

@@ sv/line_follower_pid_motor_mixer.sv @@
// Top level of the line follower PID motor mixer: config registers,
// input and result registers, controller state.
// Depends on lfpm_pkg, lfpm_classify, lfpm_pid, lfpm_mixer.
//
// Usage:
//   s_* stream: one item per control tick, three sensor samples.
//   m_* stream: one result item per input item, in order.
//   cfg_we/cfg_index/cfg_data write the seven control registers; write
//   only while no item is in flight.
// Datapath: an accepted item is registered in the input register, computed
//   and registered in the result register that drives m_tvalid.
// Throughput: one item per cycle while m_tready is high; the integral and
//   previous-error state update in the same cycle the item is computed, so
//   each item sees its predecessor's state.
// Reset: config registers return to their defaults, integral and previous error
//   clear, both streams go empty.
// Stall: with m_tready low the result register holds; one further item
//   waits in the input register, after which s_tready drops.
module line_follower_pid_motor_mixer #(
	parameter int SAMPLE_BITS = 12
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	// [11:0] left_sample, [23:12] middle_sample, [35:24] right_sample
	input  logic [39:0]                   s_tdata,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	// [2:0] line_error, [15:3] drive, [23:16] left_duty, [31:24] right_duty,
	// [33:32] bridge_code
	output logic [39:0]                   m_tdata,
	input  logic                          cfg_we,
	input  logic [lfpm_pkg::IDX_W-1:0]    cfg_index,
	input  logic [lfpm_pkg::CFG_W-1:0]    cfg_data
);
	import lfpm_pkg::*;

	logic [SAMPLE_W-1:0] threshold_q;
	logic [GAIN_W-1:0]   gain_p_q, gain_i_q, gain_d_q;
	logic [LIMIT_W-1:0]  limit_q;
	logic [SPEED_W-1:0]  base_q, max_q;

	logic                      valid_s1;
	logic [SAMPLE_W-1:0]       left_s1, middle_s1, right_s1;
	logic                      out_valid_q;
	result_t                   result_q;
	logic signed [SUM_W-1:0]   err_sum_q, err_sum_nxt;
	logic signed [ERR_W-1:0]   prev_err_q, line_error;
	logic signed [DRIVE_W-1:0] drive;
	mix_t                      mix;
	logic                      out_free, advance;

	assign out_free = !out_valid_q || m_tready;
	assign advance  = valid_s1 && out_free;
	assign s_tready = !valid_s1 || out_free;
	assign m_tvalid = out_valid_q;
	assign m_tdata  = {(40 - $bits(result_t))'(0), result_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			threshold_q <= THRESHOLD_RST;
			gain_p_q    <= GAIN_P_RST;
			gain_i_q    <= GAIN_I_RST;
			gain_d_q    <= GAIN_D_RST;
			limit_q     <= LIMIT_RST;
			base_q      <= BASE_RST;
			max_q       <= MAX_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_THRESHOLD: threshold_q <= cfg_data;
				CFG_GAIN_P:    gain_p_q    <= cfg_data;
				CFG_GAIN_I:    gain_i_q    <= cfg_data;
				CFG_GAIN_D:    gain_d_q    <= cfg_data;
				CFG_LIMIT:     limit_q     <= cfg_data[LIMIT_W-1:0];
				CFG_BASE:      base_q      <= cfg_data[SPEED_W-1:0];
				CFG_MAX:       max_q       <= cfg_data[SPEED_W-1:0];
				default:       ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
			err_sum_q   <= '0;
			prev_err_q  <= '0;
		end else begin
			if (s_tready) begin
				valid_s1 <= s_tvalid;
			end
			if (out_free) begin
				out_valid_q <= valid_s1;
			end
			if (advance) begin
				err_sum_q  <= err_sum_nxt;
				prev_err_q <= line_error;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			left_s1   <= s_tdata[11:0];
			middle_s1 <= s_tdata[23:12];
			right_s1  <= s_tdata[35:24];
		end
		if (advance) begin
			result_q.line_error <= line_error;
			result_q.drive      <= drive;
			result_q.mix        <= mix;
		end
	end

	lfpm_classify #(
		.SAMPLE_BITS(SAMPLE_BITS)
	) u_classify (
		.left_sample  (left_s1),
		.middle_sample(middle_s1),
		.right_sample (right_s1),
		.threshold    (threshold_q),
		.line_error   (line_error)
	);

	lfpm_pid u_pid (
		.line_error (line_error),
		.prev_error (prev_err_q),
		.err_sum    (err_sum_q),
		.gain_p     (gain_p_q),
		.gain_i     (gain_i_q),
		.gain_d     (gain_d_q),
		.limit      (limit_q),
		.err_sum_nxt(err_sum_nxt),
		.drive      (drive)
	);

	lfpm_mixer u_mixer (
		.drive     (drive),
		.base_speed(base_q),
		.max_speed (max_q),
		.mix       (mix)
	);

	a_ready_when_drained: assert property (@(posedge clk) disable iff (!arst_n)
		m_tready |-> s_tready)
		else $error("input stalled while output side drains");

	a_zero_clears_sum: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && line_error == 3'sd0) |=> (err_sum_q == '0))
		else $error("zero line error did not clear integral");

	a_prev_tracks_out: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> (m_tvalid && prev_err_q == result_q.line_error))
		else $error("previous error does not match last result");

	a_bridge_code_legal: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (result_q.mix.bridge_code != 2'd3))
		else $error("illegal bridge code");

endmodule
